// ----- hdl/abkf_pkg.sv -----
package abkf_pkg;

  localparam int FracBits = 24;

  localparam logic [31:0] SatMax = 32'h7FFF_FFFF;
  localparam logic [31:0] SatMin = 32'h8000_0000;

  // Configuration register indexes.
  localparam logic [1:0] RegAngleNoise   = 2'd0;
  localparam logic [1:0] RegBiasNoise    = 2'd1;
  localparam logic [1:0] RegMeasureNoise = 2'd2;
  localparam logic [1:0] RegTimeStep     = 2'd3;

  localparam logic [30:0] AngleNoiseReset   = 31'd16777;
  localparam logic [30:0] BiasNoiseReset    = 31'd50331;
  localparam logic [30:0] MeasureNoiseReset = 31'd503316;
  localparam logic [30:0] TimeStepReset     = 31'd1006633;

  // Saturate a 34-bit signed sum to 32 bits.
  function automatic logic [31:0] sat34(input logic signed [33:0] v);
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    hi = 34'sh0_7FFF_FFFF;
    lo = -34'sh0_8000_0000;
    if (v > hi) begin
      sat34 = SatMax;
    end else if (v < lo) begin
      sat34 = SatMin;
    end else begin
      sat34 = v[31:0];
    end
  endfunction

  // Round half up and saturate a Q16.48 product back to Q8.24.
  function automatic logic [31:0] qround(input logic signed [63:0] p);
    logic signed [64:0] r;
    logic signed [40:0] s;
    r = {p[63], p} + 65'sd8388608;
    s = r[64:24];
    if (s > 41'sh0_7FFF_FFFF) begin
      qround = SatMax;
    end else if (s < -41'sh0_8000_0000) begin
      qround = SatMin;
    end else begin
      qround = s[31:0];
    end
  endfunction

endpackage

// ----- hdl/angle_bias_kalman_filter_unit.sv -----
// Channel  | Direction | Signals
// request  | in        | in_valid, in_ready, measured_angle, turn_rate
// result   | out       | out_valid, out_ready, estimated_angle
// config   | in        | cfg_we, cfg_index, cfg_data
//
// A result is valid once its request has passed these steps in order: StDen
// forms the denominator and the innovation, two serial divisions run (load,
// 56 quotient bits, store the gain), ten steps run on the shared 32x32
// multiplier and StOut moves the result to the output register. The next
// request can be taken once StOut has moved the result. A request may be
// taken while a result waits; the unit holds in its last step until the
// output register is free. Reset is synchronous.
module angle_bias_kalman_filter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] measured_angle,
  input  logic [31:0] turn_rate,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] estimated_angle,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StDen  = 4'd1;
  localparam logic [3:0] StDiv  = 4'd2;
  localparam logic [3:0] StMul  = 4'd3;
  localparam logic [3:0] StOut  = 4'd4;

  localparam int DivBits = 56;

  logic [3:0]  state;
  logic [30:0] angle_noise, bias_noise, measure_noise, time_step;
  logic [31:0] angle_est, bias_est, p00, p01, p10, p11;
  logic [31:0] meas, rate_in, den, k0, k1, y;
  logic [31:0] c00, c01, dp11;
  logic [31:0] pred;
  logic        div_sel;
  logic [5:0]  div_cnt;
  logic [55:0] div_q;
  logic [31:0] div_r;
  logic [31:0] div_d;
  logic        div_neg;
  logic [3:0]  op;
  logic [31:0] ma, mb;
  logic [31:0] prod;

  // Single shared multiplier with Q8.24 rounding.
  assign prod = abkf_pkg::qround(64'($signed(ma)) * 64'($signed(mb)));

  // Serial restoring division on magnitudes.
  logic [32:0] div_trial;
  assign div_trial = {div_r, div_q[55]} - {1'b0, div_d};

  logic [31:0] num_abs, den_abs;
  logic [31:0] div_src;
  assign div_src = div_sel ? p10 : p00;
  assign num_abs = div_src[31] ? 32'(-div_src) : div_src;
  assign den_abs = den[31] ? 32'(-den) : den;

  // Quotient with sign applied and saturated.
  logic signed [56:0] q_signed;
  logic [31:0]        q_sat;
  always_comb begin
    q_signed = div_neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    if (q_signed > 57'sh7FFF_FFFF) begin
      q_sat = abkf_pkg::SatMax;
    end else if (q_signed < -57'sh8000_0000) begin
      q_sat = abkf_pkg::SatMin;
    end else begin
      q_sat = q_signed[31:0];
    end
  end

  function automatic logic [31:0] add2(input logic [31:0] a, input logic [31:0] b);
    add2 = abkf_pkg::sat34(34'($signed(a)) + 34'($signed(b)));
  endfunction
  function automatic logic [31:0] sub2(input logic [31:0] a, input logic [31:0] b);
    sub2 = abkf_pkg::sat34(34'($signed(a)) - 34'($signed(b)));
  endfunction

  // Operand selection for each multiplier step.
  logic [31:0] rate_c, inner_c;
  always_comb begin
    rate_c  = sub2(rate_in, bias_est);
    inner_c = abkf_pkg::sat34(34'($signed(dp11)) - 34'($signed(p01))
              - 34'($signed(p10)) + 34'($signed({1'b0, angle_noise})));
    ma = k0;
    mb = y;
    case (op)
      4'd0: begin ma = k0; mb = y; end
      4'd1: begin ma = k1; mb = y; end
      4'd2: begin ma = k0; mb = c00; end
      4'd3: begin ma = k0; mb = c01; end
      4'd4: begin ma = k1; mb = c00; end
      4'd5: begin ma = k1; mb = c01; end
      4'd6: begin ma = {1'b0, time_step}; mb = rate_c; end
      4'd7: begin ma = {1'b0, time_step}; mb = p11; end
      4'd8: begin ma = {1'b0, time_step}; mb = inner_c; end
      default: begin ma = {1'b0, bias_noise}; mb = {1'b0, time_step}; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      out_valid <= 1'b0;
      angle_noise <= abkf_pkg::AngleNoiseReset;
      bias_noise <= abkf_pkg::BiasNoiseReset;
      measure_noise <= abkf_pkg::MeasureNoiseReset;
      time_step <= abkf_pkg::TimeStepReset;
      angle_est <= '0;
      bias_est <= '0;
      p00 <= '0;
      p01 <= '0;
      p10 <= '0;
      p11 <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          abkf_pkg::RegAngleNoise:   angle_noise <= cfg_data;
          abkf_pkg::RegBiasNoise:    bias_noise <= cfg_data;
          abkf_pkg::RegMeasureNoise: measure_noise <= cfg_data;
          abkf_pkg::RegTimeStep:     time_step <= cfg_data;
          default: ;
        endcase
      end
      if (state == StOut && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        StIdle: begin
          if (in_valid) begin
            meas <= measured_angle;
            rate_in <= turn_rate;
            state <= StDen;
          end
        end
        StDen: begin
          den <= add2(p00, {1'b0, measure_noise});
          y <= sub2(meas, angle_est);
          c00 <= p00;
          c01 <= p01;
          div_sel <= 1'b0;
          state <= StDiv;
          div_cnt <= '0;
          div_r <= '0;
          div_q <= '0;
        end
        StDiv: begin
          if (div_cnt == 6'd0) begin
            // Load: numerator magnitude shifted up by the fraction width.
            div_q <= {num_abs, 24'd0};
            div_r <= '0;
            div_d <= den_abs;
            div_neg <= div_src[31] ^ den[31];
            div_cnt <= 6'd1;
          end else if (div_cnt <= 6'(DivBits)) begin
            if (!div_trial[32]) begin
              div_r <= div_trial[31:0];
              div_q <= {div_q[54:0], 1'b1};
            end else begin
              div_r <= {div_r[30:0], div_q[55]};
              div_q <= {div_q[54:0], 1'b0};
            end
            div_cnt <= div_cnt + 6'd1;
          end else begin
            if (!div_sel) begin
              k0 <= (den == '0) ? '0 : q_sat;
              div_sel <= 1'b1;
              div_cnt <= '0;
            end else begin
              k1 <= (den == '0) ? '0 : q_sat;
              op <= 4'd0;
              state <= StMul;
            end
          end
        end
        StMul: begin
          op <= op + 4'd1;
          case (op)
            4'd0: angle_est <= add2(angle_est, prod);
            4'd1: bias_est <= add2(bias_est, prod);
            4'd2: p00 <= sub2(p00, prod);
            4'd3: p01 <= sub2(p01, prod);
            4'd4: p10 <= sub2(p10, prod);
            4'd5: p11 <= sub2(p11, prod);
            4'd6: begin
              angle_est <= add2(angle_est, prod);
              pred <= add2(angle_est, prod);
            end
            4'd7: dp11 <= prod;
            4'd8: begin
              p00 <= add2(p00, prod);
              p01 <= sub2(p01, dp11);
              p10 <= sub2(p10, dp11);
            end
            default: begin
              p11 <= add2(p11, prod);
              state <= StOut;
            end
          endcase
        end
        StOut: begin
          if (!out_valid || out_ready) begin
            estimated_angle <= pred;
            state <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

  assign in_ready = (state == StIdle);

endmodule

// ----- hdl/abkf_checker.sv -----
module abkf_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [31:0] estimated_angle
);

  // Reset leaves no result pending and the unit ready for a request.
  a_reset: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("state after reset wrong");

  // No result appears in the cycle right after a request is taken.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result too early");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(estimated_angle)))
    else $error("stalled result changed");

  // The unit is busy after taking a request.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready again immediately after a request");

endmodule

bind angle_bias_kalman_filter_unit abkf_checker u_abkf_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .estimated_angle(estimated_angle)
);

// ----- sim/tb_angle_bias_kalman_filter_unit.sv -----
`timescale 1ns / 1ps

module tb_angle_bias_kalman_filter_unit;

  class tilt_scoreboard;
    int angle_noise, bias_noise, measure_noise, time_step;
    int angle_est, bias_est;
    int cov [4];
    int angle_queue [$];
    int errors;

    function new();
      angle_noise = int'(abkf_pkg::AngleNoiseReset);
      bias_noise = int'(abkf_pkg::BiasNoiseReset);
      measure_noise = int'(abkf_pkg::MeasureNoiseReset);
      time_step = int'(abkf_pkg::TimeStepReset);
      angle_est = 0;
      bias_est = 0;
      foreach (cov[i]) cov[i] = 0;
      errors = 0;
    endfunction

    function int clamp(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return int'(v);
    endfunction

    function int qmul(int a, int b);
      longint p;
      p = longint'(a) * longint'(b) + (64'sd1 <<< 23);
      return clamp(p >>> 24);
    endfunction

    function int qdiv(int num, int den);
      if (den == 0) return 0;
      return clamp((longint'(num) <<< 24) / longint'(den));
    endfunction

    function void set_reg(logic [1:0] idx, logic [30:0] value);
      case (idx)
        abkf_pkg::RegAngleNoise: angle_noise = int'({1'b0, value});
        abkf_pkg::RegBiasNoise: bias_noise = int'({1'b0, value});
        abkf_pkg::RegMeasureNoise: measure_noise = int'({1'b0, value});
        abkf_pkg::RegTimeStep: time_step = int'({1'b0, value});
        default: ;
      endcase
    endfunction

    // Works out the predicted angle for one accepted request.
    function void note_request(int meas, int rate_in);
      int p00, p01, p10, p11, c00, c01, den, k0, k1, y, rate, pred, dp11;
      p00 = cov[0]; p01 = cov[1]; p10 = cov[2]; p11 = cov[3];
      den = clamp(longint'(p00) + measure_noise);
      k0 = qdiv(p00, den);
      k1 = qdiv(p10, den);
      y = clamp(longint'(meas) - angle_est);
      angle_est = clamp(longint'(angle_est) + qmul(k0, y));
      bias_est = clamp(longint'(bias_est) + qmul(k1, y));
      c00 = p00; c01 = p01;
      p00 = clamp(longint'(p00) - qmul(k0, c00));
      p01 = clamp(longint'(p01) - qmul(k0, c01));
      p10 = clamp(longint'(p10) - qmul(k1, c00));
      p11 = clamp(longint'(p11) - qmul(k1, c01));
      rate = clamp(longint'(rate_in) - bias_est);
      pred = clamp(longint'(angle_est) + qmul(time_step, rate));
      angle_est = pred;
      dp11 = qmul(time_step, p11);
      p00 = clamp(longint'(p00) + qmul(time_step,
                  clamp(longint'(dp11) - p01 - p10 + angle_noise)));
      p01 = clamp(longint'(p01) - dp11);
      p10 = clamp(longint'(p10) - dp11);
      p11 = clamp(longint'(p11) + qmul(bias_noise, time_step));
      cov[0] = p00; cov[1] = p01; cov[2] = p10; cov[3] = p11;
      angle_queue.push_back(pred);
    endfunction

    function void check_result(int actual);
      int expected;
      if (angle_queue.size() == 0) begin
        $error("unexpected result: estimated_angle %h", actual);
        errors++;
        return;
      end
      expected = angle_queue.pop_front();
      if (expected != actual) begin
        $error("estimated_angle: expected %h, actual %h", expected, actual);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [31:0] measured_angle;
  logic [31:0] turn_rate;
  logic out_valid;
  logic out_ready;
  logic [31:0] estimated_angle;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [30:0] cfg_data;

  tilt_scoreboard sb;
  bit quiet;
  bit hold_req;
  int cycles;

  localparam int CycleLimit = 1500000;

  angle_bias_kalman_filter_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .measured_angle(measured_angle), .turn_rate(turn_rate),
    .out_valid(out_valid), .out_ready(out_ready),
    .estimated_angle(estimated_angle),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result(int'(estimated_angle));
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = quiet ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_request(logic [31:0] meas, logic [31:0] rate);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    measured_angle <= meas;
    turn_rate <= rate;
    do @(posedge clk); while (!in_ready);
    sb.note_request(int'(meas), int'(rate));
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    sb.set_reg(idx, value);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.angle_queue.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Mostly plausible tilt angles and rates, now and then any 32-bit value.
  task automatic random_requests(int count);
    logic [31:0] m, r;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7) begin
        m = $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
        r = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
      end else begin
        m = $urandom;
        r = $urandom;
      end
      send_request(m, r);
    end
    quiet = 1'b0;
  endtask

  initial begin
    logic [31:0] edge_vals [6];
    sb = new();
    quiet = 1'b0;
    hold_req = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    measured_angle = '0;
    turn_rate = '0;
    cfg_we = 1'b0;
    cfg_index = abkf_pkg::RegAngleNoise;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    edge_vals = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                  32'h0100_0000, 32'hFF00_0000};
    for (int a = 0; a < 6; a++) begin
      send_request(edge_vals[a], edge_vals[(a + 2) % 6]);
      send_request(edge_vals[(a + 3) % 6], edge_vals[a]);
    end
    for (int a = 0; a < 8; a++) send_request(32'h0080_0000, 32'h0000_0000);
    drain();

    // Long hold-off at the receiver while requests keep coming.
    hold_req = 1'b1;
    random_requests(250);
    drain();

    write_reg(abkf_pkg::RegAngleNoise, 31'd0);
    write_reg(abkf_pkg::RegBiasNoise, 31'd0);
    write_reg(abkf_pkg::RegMeasureNoise, 31'd1);
    write_reg(abkf_pkg::RegTimeStep, 31'd1);
    random_requests(230);
    drain();

    write_reg(abkf_pkg::RegAngleNoise, 31'h7FFF_FFFF);
    write_reg(abkf_pkg::RegBiasNoise, 31'h7FFF_FFFF);
    write_reg(abkf_pkg::RegMeasureNoise, 31'h7FFF_FFFF);
    write_reg(abkf_pkg::RegTimeStep, 31'h7FFF_FFFF);
    random_requests(230);
    drain();

    write_reg(abkf_pkg::RegAngleNoise, 31'd16777);
    write_reg(abkf_pkg::RegBiasNoise, 31'd50331);
    write_reg(abkf_pkg::RegMeasureNoise, 31'd1);
    write_reg(abkf_pkg::RegTimeStep, 31'h0100_0000);
    random_requests(230);
    drain();

    for (int p = 0; p < 4; p++) begin
      write_reg(abkf_pkg::RegAngleNoise, 31'($urandom));
      write_reg(abkf_pkg::RegBiasNoise, 31'($urandom_range(0, 32'h0100_0000)));
      write_reg(abkf_pkg::RegMeasureNoise, 31'($urandom_range(1, 32'h0200_0000)));
      write_reg(abkf_pkg::RegTimeStep, 31'($urandom_range(1, 32'h0200_0000)));
      random_requests(190);
      drain();
    end

    if (sb.angle_queue.size() > 0) begin
      $error("%0d expected results never arrived", sb.angle_queue.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
